FILE: rtl/scw_pkg.sv
// Types and constants shared by the scroll cursor window modules.
package scw_pkg;

    localparam int S_TDATA_W = 136;
    localparam int M_TDATA_W = 104;

    localparam logic KIND_FETCH   = 1'b0;
    localparam logic KIND_RESOLVE = 1'b1;

    localparam logic [2:0] ORIENT_NEXT     = 3'd1;
    localparam logic [2:0] ORIENT_FIRST    = 3'd2;
    localparam logic [2:0] ORIENT_LAST     = 3'd3;
    localparam logic [2:0] ORIENT_PRIOR    = 3'd4;
    localparam logic [2:0] ORIENT_ABSOLUTE = 3'd5;
    localparam logic [2:0] ORIENT_RELATIVE = 3'd6;

    typedef enum logic [1:0] {
        POS_BEFORE = 2'd0,
        POS_ROWSET = 2'd1,
        POS_AFTER  = 2'd2
    } pos_t;

    typedef struct packed {
        pos_t        pos;
        logic [31:0] start;
        logic [31:0] size;
        logic [31:0] prev;
    } cursor_t;

    typedef struct packed {
        logic        kind;
        logic [2:0]  orient;
        logic [31:0] offset;
        logic [31:0] rowset;
        logic [31:0] row;
        logic [31:0] visible;
    } item_t;

    typedef struct packed {
        pos_t        pos;
        logic [32:0] start;
        logic        overlap;
    } target_t;

    typedef struct packed {
        logic [31:0] rows_fetched;
        logic        overlapped_start;
        logic [1:0]  window_position;
        logic [32:0] row_number;
        logic        row_valid;
        logic [31:0] absolute_row;
    } result_t;

endpackage

FILE: rtl/scroll_cursor_window.sv
// Top level of the scrollable cursor window tracker.
//
// One command beat enters on the s_ channel and one result beat leaves on
// the m_ channel for every command. s_tuser carries the kind: a fetch moves
// the window by the orientation in s_tdata, a resolve maps a row of the
// current rowset to its absolute row index and leaves the cursor alone.
// total_rows is written through cfg_wr_en and cfg_wr_data; the user must
// write it only while no command is in flight, which the block does not enforce.
// A command taken at one clock edge sits in an input register, is worked
// out against the cursor state, and its result is captured in the result
// register, which drives m_tvalid and m_tdata.
// A command can be taken at every edge while the receiver keeps up, so
// throughput is one per cycle; the cursor state update is worked out
// combinationally between input register and result register.
// When the receiver stalls, the result register holds its beat and the
// input register keeps one more command; s_tready falls once both are full.
// Synchronous reset clears both registers, puts the cursor before the first
// row with an empty window and sets total_rows to zero.
module scroll_cursor_window #(
    parameter int ROW_BITS = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [31:0]                   cfg_wr_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // orientation, fetch_offset, rowset_size, max_rows, row_in_rowset
    input  logic [scw_pkg::S_TDATA_W-1:0] s_tdata,
    // kind
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // rows_fetched, overlapped_start, window_position, row_number,
    // row_valid, absolute_row
    output logic [scw_pkg::M_TDATA_W-1:0] m_tdata
);

    logic [31:0]      total_rows_reg;
    logic             in_valid_reg;
    scw_pkg::item_t   in_item_reg;
    scw_pkg::item_t   in_item_next;
    logic             out_valid_reg;
    scw_pkg::result_t out_res_reg;
    scw_pkg::cursor_t cur_reg;
    scw_pkg::cursor_t cur_next;
    scw_pkg::result_t res_next;
    logic             out_free;
    logic             fire;
    logic             in_take;
    logic [31:0]      max_rows;

    assign out_free = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign in_take  = s_tvalid && s_tready;
    assign max_rows = s_tdata[98:67];

    always_comb begin
        in_item_next.kind   = s_tuser;
        in_item_next.orient = s_tdata[2:0];
        in_item_next.offset = s_tdata[34:3];
        in_item_next.rowset = s_tdata[66:35];
        in_item_next.row    = s_tdata[130:99];
        if (max_rows == 32'd0 || max_rows > total_rows_reg) begin
            in_item_next.visible = total_rows_reg;
        end else begin
            in_item_next.visible = max_rows;
        end
    end

    scw_step #(
        .ROW_BITS(ROW_BITS)
    ) u_step (
        .cur  (cur_reg),
        .item (in_item_reg),
        .nxt  (cur_next),
        .res  (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_rows_reg <= 32'd0;
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            cur_reg.pos    <= scw_pkg::POS_BEFORE;
            cur_reg.start  <= 32'd0;
            cur_reg.size   <= 32'd0;
            cur_reg.prev   <= 32'd0;
        end else begin
            if (cfg_wr_en) begin
                total_rows_reg <= cfg_wr_data;
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
            if (fire) begin
                cur_reg <= cur_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_item_reg <= in_item_next;
        end
        if (fire) begin
            out_res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000,
                       out_res_reg.absolute_row,
                       out_res_reg.row_valid,
                       out_res_reg.row_number,
                       out_res_reg.window_position,
                       out_res_reg.overlapped_start,
                       out_res_reg.rows_fetched};

`ifndef ASSERT_OFF
    a_boundary_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        cur_reg.pos != scw_pkg::POS_ROWSET |-> cur_reg.start == 32'd0 && cur_reg.size == 32'd0)
        else $error("cursor off a rowset keeps a window");

    a_rowset_size: assert property (@(posedge aclk) disable iff (!aresetn)
        cur_reg.pos == scw_pkg::POS_ROWSET |-> cur_reg.size != 32'd0 &&
        cur_reg.size <= cur_reg.prev)
        else $error("rowset window size out of range");

    a_input_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !fire |=> in_valid_reg && $stable(in_item_reg))
        else $error("held command lost or changed");

    a_resolve_keeps: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && in_item_reg.kind == scw_pkg::KIND_RESOLVE |=> $stable(cur_reg))
        else $error("resolve changed the cursor");
`endif

endmodule

FILE: rtl/scw_step.sv
// Next cursor state and result for one fetch or resolve beat.
module scw_step #(
    parameter int ROW_BITS = 32
) (
    input  scw_pkg::cursor_t cur,
    input  scw_pkg::item_t   item,
    output scw_pkg::cursor_t nxt,
    output scw_pkg::result_t res
);

    localparam logic [32:0] ROW_LIMIT = (ROW_BITS >= 33) ? {33{1'b1}} :
        33'((64'd1 << ROW_BITS) - 64'd1);

    function automatic scw_pkg::target_t mk(scw_pkg::pos_t p);
        scw_pkg::target_t t;
        t.pos     = p;
        t.start   = '0;
        t.overlap = 1'b0;
        return t;
    endfunction

    function automatic scw_pkg::target_t go_forward(logic [32:0] s);
        scw_pkg::target_t t;
        t = mk(scw_pkg::POS_AFTER);
        if (s <= ROW_LIMIT) begin
            t.pos   = scw_pkg::POS_ROWSET;
            t.start = s;
        end
        return t;
    endfunction

    function automatic scw_pkg::target_t go_back(logic [31:0] origin, logic [31:0] span,
                                                 logic may_clamp, logic [31:0] requested);
        scw_pkg::target_t t;
        t = mk(scw_pkg::POS_BEFORE);
        if (span <= origin) begin
            t.pos   = scw_pkg::POS_ROWSET;
            t.start = {1'b0, origin - span};
        end else if (may_clamp && span <= requested) begin
            t.pos     = scw_pkg::POS_ROWSET;
            t.overlap = 1'b1;
        end
        return t;
    endfunction

    logic             off_neg;
    logic             off_pos;
    logic [31:0]      mag;
    logic [32:0]      off_m1;
    logic [31:0]      diff;
    scw_pkg::target_t tgt;
    scw_pkg::target_t abs_tgt;

    always_comb begin
        off_neg = item.offset[31];
        off_pos = !item.offset[31] && (item.offset != 32'd0);
        mag     = 32'd0 - item.offset;
        off_m1  = {2'b00, item.offset[30:0]} - 33'd1;

        if (off_pos) begin
            abs_tgt = go_forward(off_m1);
        end else if (off_neg) begin
            abs_tgt = go_back(item.visible, mag, item.visible != 32'd0, item.rowset);
        end else begin
            abs_tgt = mk(scw_pkg::POS_BEFORE);
        end

        case (item.orient)
            scw_pkg::ORIENT_NEXT: begin
                if (cur.pos == scw_pkg::POS_BEFORE) begin
                    tgt = mk(scw_pkg::POS_ROWSET);
                end else if (cur.pos == scw_pkg::POS_AFTER) begin
                    tgt = mk(scw_pkg::POS_AFTER);
                end else begin
                    tgt = go_forward({1'b0, cur.start} + {1'b0, cur.prev});
                end
            end
            scw_pkg::ORIENT_FIRST: begin
                tgt = mk(scw_pkg::POS_ROWSET);
            end
            scw_pkg::ORIENT_LAST: begin
                if (item.visible == 32'd0) begin
                    tgt = mk(scw_pkg::POS_AFTER);
                end else begin
                    tgt = mk(scw_pkg::POS_ROWSET);
                    if (item.visible > item.rowset) begin
                        tgt.start = {1'b0, item.visible - item.rowset};
                    end
                end
            end
            scw_pkg::ORIENT_PRIOR: begin
                if (cur.pos == scw_pkg::POS_BEFORE) begin
                    tgt = mk(scw_pkg::POS_BEFORE);
                end else if (cur.pos == scw_pkg::POS_AFTER) begin
                    tgt = go_back(item.visible, item.rowset, item.visible != 32'd0,
                                  item.rowset);
                end else begin
                    tgt = go_back(cur.start, item.rowset, cur.start != 32'd0, item.rowset);
                end
            end
            scw_pkg::ORIENT_ABSOLUTE: begin
                tgt = abs_tgt;
            end
            scw_pkg::ORIENT_RELATIVE: begin
                if (cur.pos == scw_pkg::POS_BEFORE) begin
                    tgt = off_pos ? abs_tgt : mk(scw_pkg::POS_BEFORE);
                end else if (cur.pos == scw_pkg::POS_AFTER) begin
                    tgt = off_neg ? abs_tgt : mk(scw_pkg::POS_AFTER);
                end else if (!off_neg) begin
                    tgt = go_forward({1'b0, cur.start} + {1'b0, item.offset});
                end else begin
                    tgt = go_back(cur.start, mag, cur.start != 32'd0, item.rowset);
                end
            end
            default: begin
                tgt = mk((cur.pos == scw_pkg::POS_AFTER) ? scw_pkg::POS_AFTER :
                         scw_pkg::POS_BEFORE);
            end
        endcase

        diff = item.visible - tgt.start[31:0];

        nxt = cur;
        res = '0;
        if (item.kind == scw_pkg::KIND_FETCH) begin
            nxt.start = 32'd0;
            nxt.size  = 32'd0;
            if (item.rowset == 32'd0) begin
                nxt.pos = scw_pkg::POS_BEFORE;
            end else if (tgt.pos != scw_pkg::POS_ROWSET) begin
                nxt.pos = tgt.pos;
            end else if (tgt.start >= {1'b0, item.visible}) begin
                nxt.pos = scw_pkg::POS_AFTER;
            end else begin
                nxt.pos   = scw_pkg::POS_ROWSET;
                nxt.start = tgt.start[31:0];
                nxt.size  = (diff < item.rowset) ? diff : item.rowset;
                nxt.prev  = item.rowset;
                res.rows_fetched     = nxt.size;
                res.overlapped_start = tgt.overlap;
            end
        end else if (cur.pos == scw_pkg::POS_ROWSET && item.row < cur.size) begin
            res.row_valid    = 1'b1;
            res.absolute_row = cur.start + item.row;
        end

        res.window_position = nxt.pos;
        if (nxt.pos == scw_pkg::POS_ROWSET) begin
            res.row_number = {1'b0, nxt.start} + 33'd1;
        end
    end

endmodule

FILE: dv/scw_checker.sv
// Checker for the scroll cursor window: predicts each result beat and compares it.
module scw_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [31:0]                   cfg_wr_data,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [scw_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          s_tuser,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [scw_pkg::M_TDATA_W-1:0] m_tdata,
    output int                            pending,
    output int                            errors
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        scw_pkg::pos_t pos;
        logic [63:0]   start;
        bit            clamped;
    } move_t;

    logic [31:0]      total_rows;
    scw_pkg::pos_t    cur_pos;
    logic [31:0]      win_start;
    logic [31:0]      win_size;
    logic [31:0]      last_rowset;
    scw_pkg::result_t expected_q[$];
    scw_pkg::result_t want;

    function automatic move_t make_move(scw_pkg::pos_t p, logic [63:0] s, bit c);
        move_t m;
        m.pos = p;
        m.start = s;
        m.clamped = c;
        return m;
    endfunction

    function automatic move_t move_forward(logic [63:0] s);
        if (s > 64'hFFFF_FFFF) return make_move(scw_pkg::POS_AFTER, 64'd0, 1'b0);
        return make_move(scw_pkg::POS_ROWSET, s, 1'b0);
    endfunction

    function automatic move_t move_back(logic [63:0] origin, logic [63:0] span,
                                        bit may_clamp, logic [63:0] requested);
        if (span <= origin) return make_move(scw_pkg::POS_ROWSET, origin - span, 1'b0);
        if (may_clamp && span <= requested)
            return make_move(scw_pkg::POS_ROWSET, 64'd0, 1'b1);
        return make_move(scw_pkg::POS_BEFORE, 64'd0, 1'b0);
    endfunction

    function automatic move_t move_absolute(logic signed [31:0] off, logic [31:0] visible,
                                            logic [31:0] requested);
        logic [31:0] mag;
        mag = ~off + 32'd1;
        if (off > 0) return move_forward({32'b0, off} - 64'd1);
        if (off == 0) return make_move(scw_pkg::POS_BEFORE, 64'd0, 1'b0);
        return move_back({32'b0, visible}, {32'b0, mag}, visible != 0, {32'b0, requested});
    endfunction

    // Works out the result of one command and, for a fetch, advances the cursor.
    function automatic scw_pkg::result_t apply_command(logic kind, logic [2:0] orient,
                                                       logic signed [31:0] offset,
                                                       logic [31:0] rowset,
                                                       logic [31:0] maxr,
                                                       logic [31:0] row);
        scw_pkg::result_t r;
        move_t            m;
        logic [31:0]      visible;
        logic [31:0]      origin;
        r = '0;
        if (kind == scw_pkg::KIND_FETCH) begin
            if (rowset == 32'd0) begin
                cur_pos = scw_pkg::POS_BEFORE;
                win_start = '0;
                win_size = '0;
            end else begin
                visible = (maxr == 32'd0 || maxr > total_rows) ? total_rows : maxr;
                case (orient)
                    scw_pkg::ORIENT_NEXT: begin
                        if (cur_pos == scw_pkg::POS_BEFORE)
                            m = make_move(scw_pkg::POS_ROWSET, 64'd0, 1'b0);
                        else if (cur_pos == scw_pkg::POS_AFTER)
                            m = make_move(scw_pkg::POS_AFTER, 64'd0, 1'b0);
                        else
                            m = move_forward({32'b0, win_start} + {32'b0, last_rowset});
                    end
                    scw_pkg::ORIENT_FIRST: m = make_move(scw_pkg::POS_ROWSET, 64'd0, 1'b0);
                    scw_pkg::ORIENT_LAST: begin
                        if (visible == 32'd0)
                            m = make_move(scw_pkg::POS_AFTER, 64'd0, 1'b0);
                        else
                            m = make_move(scw_pkg::POS_ROWSET,
                                          {32'b0, (visible > rowset) ? visible - rowset : 32'd0},
                                          1'b0);
                    end
                    scw_pkg::ORIENT_PRIOR: begin
                        if (cur_pos == scw_pkg::POS_BEFORE) begin
                            m = make_move(scw_pkg::POS_BEFORE, 64'd0, 1'b0);
                        end else begin
                            origin = (cur_pos == scw_pkg::POS_AFTER) ? visible : win_start;
                            m = move_back({32'b0, origin}, {32'b0, rowset}, origin != 0,
                                          {32'b0, rowset});
                        end
                    end
                    scw_pkg::ORIENT_ABSOLUTE: m = move_absolute(offset, visible, rowset);
                    scw_pkg::ORIENT_RELATIVE: begin
                        if (cur_pos == scw_pkg::POS_BEFORE)
                            m = (offset > 0) ? move_absolute(offset, visible, rowset)
                                             : make_move(scw_pkg::POS_BEFORE, 64'd0, 1'b0);
                        else if (cur_pos == scw_pkg::POS_AFTER)
                            m = (offset < 0) ? move_absolute(offset, visible, rowset)
                                             : make_move(scw_pkg::POS_AFTER, 64'd0, 1'b0);
                        else if (offset >= 0)
                            m = move_forward({32'b0, win_start} + {32'b0, offset});
                        else
                            m = move_back({32'b0, win_start}, {32'b0, ~offset + 32'd1},
                                          win_start != 0, {32'b0, rowset});
                    end
                    default: begin
                        m = make_move((cur_pos == scw_pkg::POS_AFTER) ? scw_pkg::POS_AFTER
                                                                      : scw_pkg::POS_BEFORE,
                                      64'd0, 1'b0);
                    end
                endcase
                if (m.pos != scw_pkg::POS_ROWSET || m.start >= {32'b0, visible}) begin
                    cur_pos = (m.pos == scw_pkg::POS_ROWSET) ? scw_pkg::POS_AFTER : m.pos;
                    win_start = '0;
                    win_size = '0;
                end else begin
                    cur_pos = scw_pkg::POS_ROWSET;
                    win_start = m.start[31:0];
                    win_size = (visible - win_start < rowset) ? visible - win_start : rowset;
                    last_rowset = rowset;
                    r.rows_fetched = win_size;
                    r.overlapped_start = m.clamped;
                end
            end
        end else if (cur_pos == scw_pkg::POS_ROWSET && row < win_size) begin
            r.row_valid = 1'b1;
            r.absolute_row = win_start + row;
        end
        r.window_position = cur_pos;
        r.row_number = (cur_pos == scw_pkg::POS_ROWSET) ? {1'b0, win_start} + 33'd1 : 33'd0;
        return r;
    endfunction

    task automatic check_field(string name, logic [63:0] want_v, logic [63:0] got_v);
        if (want_v !== got_v) begin
            $error("%s: expected %0h, got %0h", name, want_v, got_v);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            total_rows = '0;
            cur_pos = scw_pkg::POS_BEFORE;
            win_start = '0;
            win_size = '0;
            last_rowset = '0;
            expected_q.delete();
            pending = 0;
        end else begin
            if (cfg_wr_en)
                total_rows = cfg_wr_data;
            if (s_tvalid && s_tready)
                expected_q.insert(expected_q.size(),
                                  apply_command(s_tuser, s_tdata[2:0], s_tdata[34:3],
                                                s_tdata[66:35], s_tdata[98:67],
                                                s_tdata[130:99]));
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    $error("result beat with no command waiting");
                    errors++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("rows_fetched", want.rows_fetched, m_tdata[31:0]);
                    check_field("overlapped_start", want.overlapped_start, m_tdata[32]);
                    check_field("window_position", want.window_position, m_tdata[34:33]);
                    check_field("row_number", want.row_number, m_tdata[67:35]);
                    check_field("row_valid", want.row_valid, m_tdata[68]);
                    check_field("absolute_row", want.absolute_row, m_tdata[100:69]);
                end
            end
            pending = expected_q.size();
        end
    end

endmodule

FILE: dv/tb_scroll_cursor_window.sv
// Testbench top for the scroll cursor window: clock, reset, stimulus and verdict.
module tb_scroll_cursor_window;
    import scw_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] ORIENT_NONE  = 3'd0;
    localparam logic [2:0] ORIENT_SPARE = 3'd7;
    localparam int         STALL_LIMIT  = 5000;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [31:0]          cfg_wr_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    int                   pending;
    int                   errors;
    bit                   calm = 1'b0;
    int                   stall_left = 0;
    int                   quiet_cycles = 0;
    logic [31:0]          total_now = '0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    scroll_cursor_window #(.ROW_BITS(32)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    scw_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .pending(pending), .errors(errors)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 2);
        if (r < 95) return $urandom_range(3, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] pick_count(logic [31:0] total);
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return 32'd0;
        if (r < 10) return 32'hFFFF_FFFF;
        if (r < 20) return $urandom;
        if (r < 40) return total + 32'($urandom_range(0, 6)) - 32'd3;
        return 32'($urandom_range(1, 16));
    endfunction

    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 99) < 20) begin
            stall_left = pick_gap() - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || cfg_wr_en || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("scroll_cursor_window: mismatch");
            $finish;
        end
    end

    task automatic send_cmd(logic kind, logic [2:0] orient, logic [31:0] offset,
                            logic [31:0] rowset, logic [31:0] maxr, logic [31:0] row);
        int gap;
        gap = (!calm && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {5'b0, row, maxr, rowset, offset, orient};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_total(logic [31:0] value);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        total_now = value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        logic [2:0]  orients[14];
        logic [31:0] edge_offsets[5];
        logic        kind;
        logic [31:0] offset;
        logic [31:0] row;
        logic [31:0] maxr;
        int          r;

        orients = '{ORIENT_NEXT, ORIENT_FIRST, ORIENT_LAST, ORIENT_PRIOR, ORIENT_ABSOLUTE,
                    ORIENT_RELATIVE, ORIENT_NEXT, ORIENT_FIRST, ORIENT_LAST, ORIENT_PRIOR,
                    ORIENT_ABSOLUTE, ORIENT_RELATIVE, ORIENT_NONE, ORIENT_SPARE};
        edge_offsets = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd1};
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_tvalid = 1'b0;
        s_tuser = 1'b0;
        s_tdata = '0;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // With no rows every move ends off a rowset.
        send_cmd(KIND_RESOLVE, ORIENT_NONE, 32'd0, 32'd0, 32'd0, 32'd0);
        send_cmd(KIND_FETCH, ORIENT_LAST, 32'd0, 32'd5, 32'd0, 32'd0);
        send_cmd(KIND_FETCH, ORIENT_FIRST, 32'd0, 32'd5, 32'd0, 32'd0);
        send_cmd(KIND_FETCH, ORIENT_ABSOLUTE, 32'hFFFF_FFFF, 32'd5, 32'd0, 32'd0);

        write_total(32'd100);
        send_cmd(KIND_FETCH, ORIENT_NEXT, 32'd0, 32'd10, 32'd0, 32'd0);
        send_cmd(KIND_RESOLVE, ORIENT_NONE, 32'd0, 32'd0, 32'd0, 32'd9);
        send_cmd(KIND_RESOLVE, ORIENT_NONE, 32'd0, 32'd0, 32'd0, 32'd10);
        send_cmd(KIND_FETCH, ORIENT_NEXT, 32'd0, 32'd10, 32'd0, 32'd0);
        send_cmd(KIND_FETCH, ORIENT_PRIOR, 32'd0, 32'd10, 32'd0, 32'd0);
        send_cmd(KIND_FETCH, ORIENT_PRIOR, 32'd0, 32'd10, 32'd0, 32'd0);
        send_cmd(KIND_FETCH, ORIENT_RELATIVE, 32'hFFFF_FFFC, 32'd3, 32'd0, 32'd0);
        send_cmd(KIND_FETCH, ORIENT_RELATIVE, 32'd3, 32'd5, 32'd0, 32'd0);
        send_cmd(KIND_FETCH, ORIENT_RELATIVE, 32'hFFFF_FFFB, 32'd5, 32'd0, 32'd0);
        send_cmd(KIND_FETCH, ORIENT_LAST, 32'd0, 32'd30, 32'd0, 32'd0);
        send_cmd(KIND_FETCH, ORIENT_LAST, 32'd0, 32'hFFFF_FFFF, 32'd20, 32'd0);
        send_cmd(KIND_FETCH, ORIENT_NEXT, 32'd0, 32'd1, 32'd0, 32'd0);
        send_cmd(KIND_FETCH, ORIENT_RELATIVE, 32'd5, 32'd1, 32'd0, 32'd0);
        send_cmd(KIND_FETCH, ORIENT_PRIOR, 32'd0, 32'd10, 32'hFFFF_FFFF, 32'd0);
        send_cmd(KIND_FETCH, ORIENT_ABSOLUTE, 32'h8000_0000, 32'hFFFF_FFFF, 32'd0, 32'd0);
        send_cmd(KIND_FETCH, ORIENT_ABSOLUTE, 32'h7FFF_FFFF, 32'd1, 32'd0, 32'd0);
        send_cmd(KIND_FETCH, ORIENT_RELATIVE, 32'hFFFF_FFFF, 32'd1, 32'd0, 32'd0);
        send_cmd(KIND_FETCH, ORIENT_NONE, 32'd0, 32'd1, 32'd0, 32'd0);
        send_cmd(KIND_FETCH, ORIENT_FIRST, 32'd0, 32'd0, 32'd0, 32'd0);

        // Near the top of the row range a forward sum leaves the 32-bit space.
        write_total(32'hFFFF_FFFF);
        send_cmd(KIND_FETCH, ORIENT_LAST, 32'd0, 32'd1, 32'd0, 32'd0);
        send_cmd(KIND_FETCH, ORIENT_NEXT, 32'd0, 32'd1, 32'd0, 32'd0);
        send_cmd(KIND_FETCH, ORIENT_LAST, 32'd0, 32'd1, 32'd0, 32'd0);
        send_cmd(KIND_FETCH, ORIENT_RELATIVE, 32'h7FFF_FFFF, 32'd1, 32'd0, 32'd0);

        for (int p = 0; p < 12; p++) begin
            if (p == 0)
                write_total(32'd0);
            else if (p == 1)
                write_total(32'hFFFF_FFFF);
            else
                case ($urandom_range(0, 4))
                    0: write_total(32'($urandom_range(1, 8)));
                    1: write_total(32'($urandom_range(1, 200)));
                    2: write_total(32'($urandom_range(1, 100000)));
                    3: write_total(32'hFFFF_FFFF - 32'($urandom_range(0, 4)));
                    default: write_total($urandom);
                endcase
            calm = ($urandom_range(0, 3) == 0);
            repeat (95) begin
                kind = ($urandom_range(0, 99) < 30) ? KIND_RESOLVE : KIND_FETCH;
                r = $urandom_range(0, 99);
                if (r < 10)
                    offset = edge_offsets[$urandom_range(0, 4)];
                else if (r < 25)
                    offset = $urandom;
                else if (r < 50) begin
                    offset = total_now + 32'($urandom_range(0, 6)) - 32'd3;
                    if ($urandom_range(0, 1)) offset = ~offset + 32'd1;
                end else
                    offset = 32'($urandom_range(0, 40)) - 32'd20;
                r = $urandom_range(0, 99);
                if (r < 10)
                    row = $urandom;
                else if (r < 15)
                    row = 32'hFFFF_FFFF;
                else
                    row = 32'($urandom_range(0, 20));
                maxr = $urandom_range(0, 1) ? 32'd0 : pick_count(total_now);
                send_cmd(kind, orients[$urandom_range(0, 13)], offset, pick_count(total_now),
                         maxr, row);
            end
        end

        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);
        if (errors == 0)
            $display("scroll_cursor_window: match");
        else
            $display("scroll_cursor_window: mismatch");
        $finish;
    end

endmodule
